/* hw/rtl/v3m_pkg.sv */
// ----------------------------------------------------------------------------
// v3m_pkg
// Shared widths, opcodes, pipeline record types and the saturation helper
// for the three-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v3m_pkg;

  // Number format and derived widths
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int CMD_W     = 4;
  localparam int RAD_W     = 2 * DATA_W;             // full product / radicand
  localparam int QP_W      = RAD_W - FRAC_BITS;      // product after rescale
  localparam int NUM_W     = DATA_W + FRAC_BITS;     // dividend and quotient
  localparam int SUM_W     = (QP_W > NUM_W) ? QP_W + 2 : NUM_W + 2;
  localparam int SQ_STAGES = DATA_W;                 // one root bit per stage
  localparam int LATENCY   = 4 + SQ_STAGES + NUM_W;  // accept to result strobe

  // Opcodes
  localparam logic [CMD_W-1:0] OP_ADD    = CMD_W'(0);
  localparam logic [CMD_W-1:0] OP_SUB    = CMD_W'(1);
  localparam logic [CMD_W-1:0] OP_SCALE  = CMD_W'(2);
  localparam logic [CMD_W-1:0] OP_DIV    = CMD_W'(3);
  localparam logic [CMD_W-1:0] OP_DOT    = CMD_W'(4);
  localparam logic [CMD_W-1:0] OP_CROSS  = CMD_W'(5);
  localparam logic [CMD_W-1:0] OP_EQUAL  = CMD_W'(6);
  localparam logic [CMD_W-1:0] OP_LENGTH = CMD_W'(7);
  localparam logic [CMD_W-1:0] OP_NORM   = CMD_W'(8);

  // Result fields as they travel down the pipe
  typedef struct packed {
    logic [2:0][DATA_W-1:0] r;
    logic [DATA_W-1:0]      rs;
    logic                   eq;
    logic                   ov;
    logic                   dz;
  } res_t;

  // Sideband riding alongside the square root
  typedef struct packed {
    res_t                  res;
    logic [CMD_W-1:0]      cmd;
    logic [2:0]            neg;
    logic [2:0][NUM_W-1:0] num;
    logic [DATA_W-1:0]     s_mag;
  } side_t;

  // Sideband riding alongside the divider
  typedef struct packed {
    res_t             res;
    logic [CMD_W-1:0] cmd;
    logic [2:0]       neg;
  } tail_t;

  typedef struct packed {
    logic              ov;
    logic [DATA_W-1:0] v;
  } sat_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t o;
    if (v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
      o.ov = 1'b1;
      o.v  = {v[SUM_W-1], {(DATA_W-1){~v[SUM_W-1]}}};
    end else begin
      o.ov = 1'b0;
      o.v  = v[DATA_W-1:0];
    end
    return o;
  endfunction

endpackage

/* hw/rtl/v3m_sqrt.sv */
// ----------------------------------------------------------------------------
// v3m_sqrt
// Pipelined integer square root: floor(sqrt(radicand)), one root bit per
// stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module v3m_sqrt
  import v3m_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_vld,
  output logic [DATA_W-1:0] out_root
);

  logic              vld_r  [SQ_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQ_STAGES];
  logic [DATA_W:0]   rem_r  [SQ_STAGES];
  logic [DATA_W-1:0] root_r [SQ_STAGES];

  logic              vld_nxt  [SQ_STAGES];
  logic [RAD_W-1:0]  rad_nxt  [SQ_STAGES];
  logic [DATA_W:0]   rem_nxt  [SQ_STAGES];
  logic [DATA_W-1:0] root_nxt [SQ_STAGES];

  // One trial subtraction per stage
  always_comb begin
    logic              vld_i;
    logic [RAD_W-1:0]  rad_i;
    logic [DATA_W:0]   rem_i;
    logic [DATA_W-1:0] root_i;
    logic [DATA_W+2:0] sh;
    logic [DATA_W+2:0] trial;
    logic              ge;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        vld_i  = in_vld;
        rad_i  = in_rad;
        rem_i  = '0;
        root_i = '0;
      end else begin
        vld_i  = vld_r[k-1];
        rad_i  = rad_r[k-1];
        rem_i  = rem_r[k-1];
        root_i = root_r[k-1];
      end
      sh    = {rem_i, rad_i[RAD_W-1:RAD_W-2]};
      trial = {1'b0, root_i, 2'b01};
      ge    = (sh >= trial);
      vld_nxt[k]  = vld_i;
      rad_nxt[k]  = {rad_i[RAD_W-3:0], 2'b00};
      // remainder never exceeds twice the root, so it needs DATA_W+1 bits
      rem_nxt[k]  = ge ? (DATA_W+1)'(sh - trial) : sh[DATA_W:0];
      root_nxt[k] = {root_i[DATA_W-2:0], ge};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];

endmodule

/* hw/rtl/v3m_div.sv */
// ----------------------------------------------------------------------------
// v3m_div
// Three-lane pipelined unsigned divider sharing one divisor. Restoring
// division, one quotient bit per stage; the dividend register shifts the
// quotient in from the bottom.
// ----------------------------------------------------------------------------
module v3m_div
  import v3m_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [2:0][NUM_W-1:0] in_num,
  input  logic [DATA_W-1:0]     in_den,
  output logic                  out_vld,
  output logic [2:0][NUM_W-1:0] out_quo
);

  logic                   vld_r [NUM_W];
  logic [DATA_W-1:0]      den_r [NUM_W];
  logic [2:0][NUM_W-1:0]  num_r [NUM_W];
  logic [2:0][DATA_W-1:0] rem_r [NUM_W];

  logic                   vld_nxt [NUM_W];
  logic [DATA_W-1:0]      den_nxt [NUM_W];
  logic [2:0][NUM_W-1:0]  num_nxt [NUM_W];
  logic [2:0][DATA_W-1:0] rem_nxt [NUM_W];

  // Shift, compare, subtract per stage and lane
  always_comb begin
    logic                   vld_i;
    logic [DATA_W-1:0]      den_i;
    logic [2:0][NUM_W-1:0]  num_i;
    logic [2:0][DATA_W-1:0] rem_i;
    logic [DATA_W:0]        sh;
    logic [DATA_W:0]        diff;
    logic                   ge;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        vld_i = in_vld;
        den_i = in_den;
        num_i = in_num;
        rem_i = '0;
      end else begin
        vld_i = vld_r[k-1];
        den_i = den_r[k-1];
        num_i = num_r[k-1];
        rem_i = rem_r[k-1];
      end
      vld_nxt[k] = vld_i;
      den_nxt[k] = den_i;
      for (int l = 0; l < 3; l++) begin
        sh   = {rem_i[l], num_i[l][NUM_W-1]};
        diff = sh - {1'b0, den_i};
        ge   = (sh >= {1'b0, den_i});
        rem_nxt[k][l] = ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
        num_nxt[k][l] = {num_i[l][NUM_W-2:0], ge};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_W; k++) begin
      den_r[k] <= den_nxt[k];
      num_r[k] <= num_nxt[k];
      rem_r[k] <= rem_nxt[k];
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign out_quo = num_r[NUM_W-1];

endmodule

/* hw/rtl/vec3_math_unit.sv */
// ----------------------------------------------------------------------------
// vec3_math_unit
// Three-component Q16.16 vector unit: add, sub, scale, divide, dot, cross,
// equal, length and normalize, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Takes one transaction every clock cycle: busy is always low, so a start
// pulse in any cycle is accepted. Every transaction, whatever its opcode,
// produces exactly one result, strobed by out_valid for one cycle, in the
// order the transactions came in. The latency is set by the 32-stage square
// root (one root bit per stage) followed by the 48-stage divider (one
// quotient bit per stage), plus four stages for input, multiply,
// rescale/sum and output. Nothing can stall the result side; capture out_*
// whenever out_valid is high.
// ----------------------------------------------------------------------------
module vec3_math_unit
  import v3m_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DATA_W-1:0] in_a_x,
  input  logic signed [DATA_W-1:0] in_a_y,
  input  logic signed [DATA_W-1:0] in_a_z,
  input  logic signed [DATA_W-1:0] in_b_x,
  input  logic signed [DATA_W-1:0] in_b_y,
  input  logic signed [DATA_W-1:0] in_b_z,
  input  logic signed [DATA_W-1:0] in_scalar,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_r_x,
  output logic signed [DATA_W-1:0] out_r_y,
  output logic signed [DATA_W-1:0] out_r_z,
  output logic signed [DATA_W-1:0] out_r_scalar,
  output logic                     out_is_equal,
  output logic                     out_overflow,
  output logic                     out_div_zero
);

  // Stage 1: input registers
  logic                     vld1_r;
  logic [CMD_W-1:0]         cmd1_r;
  logic signed [DATA_W-1:0] a1_r [3];
  logic signed [DATA_W-1:0] b1_r [3];
  logic signed [DATA_W-1:0] s1_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r  <= in_cmd;
    a1_r[0] <= in_a_x;
    a1_r[1] <= in_a_y;
    a1_r[2] <= in_a_z;
    b1_r[0] <= in_b_x;
    b1_r[1] <= in_b_y;
    b1_r[2] <= in_b_z;
    s1_r    <= in_scalar;
  end

  // Stage 2: six multipliers, add/sub, equality
  logic signed [DATA_W-1:0] op_a [6];
  logic signed [DATA_W-1:0] op_b [6];
  logic signed [RAD_W-1:0]  p_nxt [6];
  logic signed [DATA_W:0]   as_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i]   = a1_r[i];
      op_b[i]   = a1_r[i];
      op_a[i+3] = '0;
      op_b[i+3] = '0;
    end
    unique case (cmd1_r)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) op_b[i] = s1_r;
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) op_b[i] = b1_r[i];
      end
      OP_CROSS: begin
        op_a[0] = a1_r[1]; op_b[0] = b1_r[2];
        op_a[1] = b1_r[1]; op_b[1] = a1_r[2];
        op_a[2] = b1_r[0]; op_b[2] = a1_r[2];
        op_a[3] = a1_r[0]; op_b[3] = b1_r[2];
        op_a[4] = a1_r[0]; op_b[4] = b1_r[1];
        op_a[5] = b1_r[0]; op_b[5] = a1_r[1];
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) p_nxt[k] = op_a[k] * op_b[k];
    for (int i = 0; i < 3; i++) begin
      if (cmd1_r == OP_SUB) begin
        as_nxt[i] = (DATA_W+1)'(a1_r[i]) - (DATA_W+1)'(b1_r[i]);
      end else begin
        as_nxt[i] = (DATA_W+1)'(a1_r[i]) + (DATA_W+1)'(b1_r[i]);
      end
    end
  end

  logic                     vld2_r;
  logic [CMD_W-1:0]         cmd2_r;
  logic signed [RAD_W-1:0]  p2_r [6];
  logic signed [DATA_W:0]   as2_r [3];
  logic                     eq2_r;
  logic signed [DATA_W-1:0] a2_r [3];
  logic signed [DATA_W-1:0] s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd2_r <= cmd1_r;
    p2_r   <= p_nxt;
    as2_r  <= as_nxt;
    eq2_r  <= (a1_r[0] == b1_r[0]) && (a1_r[1] == b1_r[1]) && (a1_r[2] == b1_r[2]);
    a2_r   <= a1_r;
    s2_r   <= s1_r;
  end

  // Stage 3: rescale products, sum, saturate, prepare division operands
  logic signed [QP_W-1:0]  qp [6];
  logic signed [SUM_W-1:0] qe [6];
  side_t                   side3_nxt;
  logic [RAD_W-1:0]        ss_nxt;

  always_comb begin
    sat_t              st;
    logic [DATA_W-1:0] mag;
    st = '0;
    for (int k = 0; k < 6; k++) begin
      qp[k] = p2_r[k][RAD_W-1:FRAC_BITS];
      qe[k] = SUM_W'(qp[k]);
    end
    side3_nxt     = '0;
    side3_nxt.cmd = cmd2_r;
    unique case (cmd2_r)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          st = sat32(SUM_W'(as2_r[i]));
          side3_nxt.res.r[i] = st.v;
          side3_nxt.res.ov   = side3_nxt.res.ov | st.ov;
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          st = sat32(qe[i]);
          side3_nxt.res.r[i] = st.v;
          side3_nxt.res.ov   = side3_nxt.res.ov | st.ov;
        end
      end
      OP_DOT: begin
        st = sat32(qe[0] + qe[1] + qe[2]);
        side3_nxt.res.rs = st.v;
        side3_nxt.res.ov = st.ov;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          st = sat32(qe[2*i] - qe[2*i+1]);
          side3_nxt.res.r[i] = st.v;
          side3_nxt.res.ov   = side3_nxt.res.ov | st.ov;
        end
      end
      OP_EQUAL: begin
        side3_nxt.res.eq = eq2_r;
      end
      default: begin
      end
    endcase
    // Dividend magnitudes and quotient signs
    for (int i = 0; i < 3; i++) begin
      mag = a2_r[i][DATA_W-1] ? DATA_W'(-a2_r[i]) : a2_r[i];
      side3_nxt.num[i] = {mag, {FRAC_BITS{1'b0}}};
      side3_nxt.neg[i] = a2_r[i][DATA_W-1] ^ ((cmd2_r == OP_DIV) && s2_r[DATA_W-1]);
    end
    side3_nxt.s_mag = s2_r[DATA_W-1] ? DATA_W'(-s2_r) : s2_r;
    // Sum of squares, exact in 64 bits
    ss_nxt = p2_r[0] + p2_r[1] + p2_r[2];
  end

  logic             vld3_r;
  side_t            side3_r;
  logic [RAD_W-1:0] ss3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= side3_nxt;
    ss3_r   <= ss_nxt;
  end

  // Square root with matching sideband delay
  logic              sq_vld;
  logic [DATA_W-1:0] sq_root;
  side_t             sq_dly_r [SQ_STAGES];

  v3m_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld3_r),
    .in_rad   (ss3_r),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  always_ff @(posedge clk) begin
    sq_dly_r[0] <= side3_r;
    for (int k = 1; k < SQ_STAGES; k++) sq_dly_r[k] <= sq_dly_r[k-1];
  end

  // Length result, divisor selection, zero-divisor check
  side_t             sq_side;
  tail_t             tail_nxt;
  logic [DATA_W-1:0] den;

  always_comb begin
    sat_t st;
    sq_side       = sq_dly_r[SQ_STAGES-1];
    tail_nxt.res  = sq_side.res;
    tail_nxt.cmd  = sq_side.cmd;
    tail_nxt.neg  = sq_side.neg;
    den           = (sq_side.cmd == OP_NORM) ? sq_root : sq_side.s_mag;
    st            = sat32(SUM_W'(sq_root));
    if (sq_side.cmd == OP_LENGTH) begin
      tail_nxt.res.rs = st.v;
      tail_nxt.res.ov = st.ov;
    end
    if ((sq_side.cmd == OP_DIV) || (sq_side.cmd == OP_NORM)) begin
      tail_nxt.res.dz = (den == '0);
    end
  end

  // Divider with matching sideband delay
  logic                  dv_vld;
  logic [2:0][NUM_W-1:0] dv_quo;
  tail_t                 tail_dly_r [NUM_W];

  v3m_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .in_num  (sq_side.num),
    .in_den  (den),
    .out_vld (dv_vld),
    .out_quo (dv_quo)
  );

  always_ff @(posedge clk) begin
    tail_dly_r[0] <= tail_nxt;
    for (int k = 1; k < NUM_W; k++) tail_dly_r[k] <= tail_dly_r[k-1];
  end

  // Final stage: signed quotient saturation, output register
  tail_t tail;
  res_t  res_nxt;

  always_comb begin
    sat_t                    st;
    logic signed [SUM_W-1:0] qs;
    st      = '0;
    qs      = '0;
    tail    = tail_dly_r[NUM_W-1];
    res_nxt = tail.res;
    if (((tail.cmd == OP_DIV) || (tail.cmd == OP_NORM)) && !tail.res.dz) begin
      for (int i = 0; i < 3; i++) begin
        qs = SUM_W'(dv_quo[i]);
        if (tail.neg[i]) qs = -qs;
        st = sat32(qs);
        res_nxt.r[i] = st.v;
        res_nxt.ov   = res_nxt.ov | st.ov;
      end
    end
  end

  logic out_vld_r;
  res_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= res_nxt;
  end

  assign out_valid    = out_vld_r;
  assign out_r_x      = out_res_r.r[0];
  assign out_r_y      = out_res_r.r[1];
  assign out_r_z      = out_res_r.r[2];
  assign out_r_scalar = out_res_r.rs;
  assign out_is_equal = out_res_r.eq;
  assign out_overflow = out_res_r.ov;
  assign out_div_zero = out_res_r.dz;

endmodule

/* hw/rtl/v3m_checker.sv */
// ----------------------------------------------------------------------------
// v3m_checker
// Port-level checks for the vector unit: fixed latency, one result per
// transaction, and consistency of the flag combinations.
// ----------------------------------------------------------------------------
module v3m_checker
  import v3m_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_r_x,
  input logic signed [DATA_W-1:0] out_r_y,
  input logic signed [DATA_W-1:0] out_r_z,
  input logic signed [DATA_W-1:0] out_r_scalar,
  input logic                     out_is_equal,
  input logic                     out_overflow,
  input logic                     out_div_zero
);

  // Unit never holds off a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  // Every accepted transaction yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("missing result");

  // No result without a transaction before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LATENCY))
    else $error("result without transaction");

  // Zero divisor gives zero vector and no overflow
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_zero) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && !out_overflow &&
       !out_is_equal && out_r_scalar == '0))
    else $error("bad divide-by-zero result");

  // Equality result carries nothing else
  a_equal_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_equal) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_scalar == '0 &&
       !out_overflow && !out_div_zero))
    else $error("bad equality result");

endmodule

bind vec3_math_unit v3m_checker u_v3m_checker (.*);
